>>> rtl/assert_macros.svh
// Assertion macros used by the checker file ibhq_checker.
// Depends on nothing; the including scope provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/ibhq_pkg.sv
// Shared constants, codes and helpers for the indexed binary heap queue.
// Depends on nothing.
package ibhq_pkg;

	localparam int ELEM_W       = 10;
	localparam int COST_W       = 32;
	localparam int STATUS_W     = 3;
	localparam int ELEM_COUNT   = 1024;
	localparam int DEF_CAPACITY = 1024;
	localparam int EPOCH_W      = 4;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd4;

	localparam logic [1:0] MK_WHITE = 2'd0;
	localparam logic [1:0] MK_GRAY  = 2'd1;
	localparam logic [1:0] MK_BLACK = 2'd2;

	// True when cost a belongs strictly above cost b under the policy.
	function automatic logic ranks_above(input logic signed [COST_W-1:0] a,
		input logic signed [COST_W-1:0] b, input logic greatest);
		ranks_above = greatest ? (a > b) : (a < b);
	endfunction

endpackage

>>> rtl/ibhq_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Depends on nothing.
module ibhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/indexed_binary_heap_queue.sv
// Indexed binary heap priority queue: sequencer, policy register, result register.
// Depends on ibhq_pkg and ibhq_ram.
//
// Usage:
// - Input channel (in_valid/in_stall) carries one beat per operation: insert,
//   remove top, update cost or reset heap, with element number and cost.
// - Output channel (out_valid/out_stall) returns exactly one beat per input
//   beat: status, removed element and cost, entry count, empty and full flags.
// - Configuration channel (cfg_valid/cfg_ready, always ready) writes
//   take_greatest; a changed value empties the heap.
// - An insert or update climbs one heap level at a time toward the root, and a
//   remove descends one level at a time from the root; refusals and a remove
//   that empties the heap skip the walk. The next beat is taken only once the
//   result is loaded and the sequencer is back in idle. Each memory has a
//   single read port, so every heap level needs its slot and element records
//   fetched in turn.
// - Reset empties the heap and runs a clearing pass over the 1024 element
//   marks, with the input stalled. Marks carry an epoch tag, so a heap
//   reset only bumps the epoch; every 16th clear repeats the clearing pass.
// - A finished result sits in the output register; the next beat is taken
//   while it waits, but its result is held back until out_stall drops.
module indexed_binary_heap_queue
	import ibhq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int SLOT_W  = $clog2(CAPACITY),
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               operation,
	input  logic [ELEM_W-1:0]        element,
	input  logic signed [COST_W-1:0] cost_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [STATUS_W-1:0]      status,
	output logic [ELEM_W-1:0]        removed_element,
	output logic signed [COST_W-1:0] removed_cost,
	output logic [CNT_W-1:0]         entry_count,
	output logic                     is_empty,
	output logic                     is_full,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     take_greatest
);

	localparam int CH_W = SLOT_W + 1;
	localparam int CMP_W = 18;

	typedef struct packed {
		logic [COST_W-1:0]  cost;
		logic [SLOT_W-1:0]  pos;
		logic [EPOCH_W-1:0] tag;
		logic [1:0]         mark;
	} elem_rec_t;

	localparam int REC_W = $bits(elem_rec_t);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_CHKMARK = 4'd2;
	localparam logic [3:0] S_UPCHECK = 4'd3;
	localparam logic [3:0] S_UPPE    = 4'd4;
	localparam logic [3:0] S_UPCMP   = 4'd5;
	localparam logic [3:0] S_PLACE   = 4'd6;
	localparam logic [3:0] S_TOPE    = 4'd7;
	localparam logic [3:0] S_TOPC    = 4'd8;
	localparam logic [3:0] S_LASTE   = 4'd9;
	localparam logic [3:0] S_LASTR   = 4'd10;
	localparam logic [3:0] S_DNL     = 4'd11;
	localparam logic [3:0] S_DNR     = 4'd12;
	localparam logic [3:0] S_DNLR    = 4'd13;
	localparam logic [3:0] S_DNRR    = 4'd14;
	localparam logic [3:0] S_DONE    = 4'd15;

	logic [3:0]               state_q;
	logic [1:0]               op_q;
	logic [ELEM_W-1:0]        elem_q;
	logic [COST_W-1:0]        cost_q;
	elem_rec_t                rec_q;
	elem_rec_t                lrec_q;
	logic [ELEM_W-1:0]        cur_e_q;
	logic [ELEM_W-1:0]        pe_q;
	logic [ELEM_W-1:0]        le_q;
	logic [ELEM_W-1:0]        re_q;
	logic [ELEM_W-1:0]        top_q;
	logic [SLOT_W-1:0]        hole_q;
	logic [CH_W-1:0]          child_q;
	logic                     has_r_q;
	logic [STATUS_W-1:0]      st_q;
	logic [ELEM_W-1:0]        rem_e_q;
	logic [COST_W-1:0]        rem_c_q;
	logic [CNT_W-1:0]         fill_q;
	logic [EPOCH_W-1:0]       epoch_q;
	logic                     sweep_act_q;
	logic [ELEM_W-1:0]        sweep_q;
	logic                     greatest_q;

	logic                     out_valid_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic [ELEM_W-1:0]        out_rem_e_q;
	logic [COST_W-1:0]        out_rem_c_q;
	logic [CNT_W-1:0]         out_count_q;
	logic                     out_empty_q;
	logic                     out_full_q;

	// Memory ports
	logic                     e_we, e_re, h_we, h_re;
	logic [ELEM_W-1:0]        e_waddr, e_raddr, h_wdata, h_rdata;
	logic [REC_W-1:0]         e_wdata, e_rdata;
	logic [SLOT_W-1:0]        h_waddr, h_raddr;

	elem_rec_t                erd;
	logic                     oor, full, in_gray, in_black, clear_req;
	logic [SLOT_W-1:0]        parent;
	logic [CH_W-1:0]          lidx, fill_ext;
	logic                     up_better, l_better, r_better, moved;
	logic [COST_W-1:0]        best_cost;
	logic [ELEM_W-1:0]        pick_e;
	elem_rec_t                pick_rec;
	logic [CH_W-1:0]          pick_idx;

	assign erd       = elem_rec_t'(e_rdata);
	assign oor       = CMP_W'(elem_q) >= CMP_W'(CAPACITY);
	assign full      = fill_q == CNT_W'(CAPACITY);
	assign in_gray   = (erd.tag == epoch_q) && (erd.mark == MK_GRAY);
	assign in_black  = (erd.tag == epoch_q) && (erd.mark == MK_BLACK);
	assign parent    = SLOT_W'((hole_q - SLOT_W'(1)) >> 1);
	assign lidx      = {hole_q, 1'b1};
	assign fill_ext  = CH_W'(fill_q);
	assign up_better = ranks_above(rec_q.cost, erd.cost, greatest_q);
	assign l_better  = ranks_above(lrec_q.cost, rec_q.cost, greatest_q);
	assign best_cost = l_better ? lrec_q.cost : rec_q.cost;
	assign r_better  = has_r_q && ranks_above(erd.cost, best_cost, greatest_q);
	assign moved     = l_better || r_better;
	assign pick_e    = r_better ? re_q : le_q;
	assign pick_rec  = r_better ? erd : lrec_q;
	assign pick_idx  = r_better ? child_q + CH_W'(1) : child_q;

	assign clear_req = ((state_q == S_DECODE) && (op_q == OP_CLEAR)) ||
		(cfg_valid && cfg_ready && (take_greatest != greatest_q));

	assign in_stall  = (state_q != S_IDLE) || sweep_act_q;
	assign cfg_ready = 1'b1;

	// Memory access per sequencer step; the clearing pass takes over the element memory's write port.
	always_comb begin
		e_we    = 1'b0;
		e_waddr = '0;
		e_wdata = '0;
		e_re    = 1'b0;
		e_raddr = '0;
		h_we    = 1'b0;
		h_waddr = '0;
		h_wdata = '0;
		h_re    = 1'b0;
		h_raddr = '0;
		case (state_q)
			S_DECODE: begin
				if ((op_q == OP_INSERT || op_q == OP_UPDATE) && !oor) begin
					e_re    = 1'b1;
					e_raddr = elem_q;
				end
				if (op_q == OP_REMOVE && fill_q != '0) begin
					h_re = 1'b1;
				end
			end
			S_UPCHECK: begin
				h_re    = hole_q != '0;
				h_raddr = parent;
			end
			S_UPPE, S_TOPE, S_LASTE, S_DNR: begin
				e_re    = 1'b1;
				e_raddr = h_rdata;
				if (state_q == S_DNR) begin
					h_re    = (child_q + CH_W'(1)) < fill_ext;
					h_raddr = SLOT_W'(child_q + CH_W'(1));
				end
			end
			S_UPCMP: begin
				if (up_better) begin
					h_we    = 1'b1;
					h_waddr = hole_q;
					h_wdata = pe_q;
					e_we    = 1'b1;
					e_waddr = pe_q;
					e_wdata = {erd.cost, hole_q, erd.tag, erd.mark};
				end
			end
			S_PLACE: begin
				h_we    = 1'b1;
				h_waddr = hole_q;
				h_wdata = cur_e_q;
				e_we    = 1'b1;
				e_waddr = cur_e_q;
				e_wdata = {rec_q.cost, hole_q, rec_q.tag, rec_q.mark};
			end
			S_TOPC: begin
				e_we    = 1'b1;
				e_waddr = top_q;
				e_wdata = {erd.cost, erd.pos, epoch_q, MK_BLACK};
				h_re    = fill_q != CNT_W'(1);
				h_raddr = SLOT_W'(fill_q - CNT_W'(1));
			end
			S_DNL: begin
				h_re    = lidx < fill_ext;
				h_raddr = SLOT_W'(lidx);
			end
			S_DNLR: begin
				e_re    = has_r_q;
				e_raddr = h_rdata;
			end
			S_DNRR: begin
				if (moved) begin
					h_we    = 1'b1;
					h_waddr = hole_q;
					h_wdata = pick_e;
					e_we    = 1'b1;
					e_waddr = pick_e;
					e_wdata = {pick_rec.cost, hole_q, pick_rec.tag, pick_rec.mark};
				end
			end
			default: begin
			end
		endcase
		if (sweep_act_q) begin
			e_we    = 1'b1;
			e_waddr = sweep_q;
			e_wdata = {COST_W'(0), SLOT_W'(0), EPOCH_W'(0), MK_WHITE};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			epoch_q      <= '0;
			sweep_act_q  <= 1'b1;
			sweep_q      <= '0;
			greatest_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				greatest_q <= take_greatest;
			end
			// Drop the beat once taken, unless a new result replaces it
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						op_q    <= operation;
						elem_q  <= element;
						cost_q  <= cost_value;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					st_q    <= ST_OK;
					rem_e_q <= '0;
					rem_c_q <= '0;
					case (op_q)
						OP_INSERT, OP_UPDATE: begin
							if (oor) begin
								st_q    <= ST_FULL;
								state_q <= S_DONE;
							end else begin
								state_q <= S_CHKMARK;
							end
						end
						OP_REMOVE: begin
							if (fill_q == '0) begin
								st_q    <= ST_EMPTY;
								state_q <= S_DONE;
							end else begin
								state_q <= S_TOPE;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_CHKMARK: begin
					cur_e_q <= elem_q;
					if (op_q == OP_INSERT && in_gray) begin
						st_q    <= ST_QUEUED;
						state_q <= S_DONE;
					end else if (op_q == OP_UPDATE && in_black) begin
						st_q    <= ST_REMOVED;
						state_q <= S_DONE;
					end else if (op_q == OP_UPDATE && in_gray) begin
						// Queued element: new cost, climb from its slot
						rec_q   <= {cost_q, erd.pos, epoch_q, MK_GRAY};
						hole_q  <= erd.pos;
						state_q <= S_UPCHECK;
					end else if (full) begin
						st_q    <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						rec_q   <= {cost_q, SLOT_W'(0), epoch_q, MK_GRAY};
						hole_q  <= SLOT_W'(fill_q);
						fill_q  <= fill_q + CNT_W'(1);
						state_q <= S_UPCHECK;
					end
				end
				S_UPCHECK: begin
					state_q <= (hole_q == '0) ? S_PLACE : S_UPPE;
				end
				S_UPPE: begin
					pe_q    <= h_rdata;
					state_q <= S_UPCMP;
				end
				S_UPCMP: begin
					if (up_better) begin
						hole_q  <= parent;
						state_q <= S_UPCHECK;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					state_q <= S_DONE;
				end
				S_TOPE: begin
					top_q   <= h_rdata;
					state_q <= S_TOPC;
				end
				S_TOPC: begin
					rem_e_q <= top_q;
					rem_c_q <= erd.cost;
					fill_q  <= fill_q - CNT_W'(1);
					state_q <= (fill_q == CNT_W'(1)) ? S_DONE : S_LASTE;
				end
				S_LASTE: begin
					cur_e_q <= h_rdata;
					state_q <= S_LASTR;
				end
				S_LASTR: begin
					rec_q   <= erd;
					hole_q  <= '0;
					state_q <= S_DNL;
				end
				S_DNL: begin
					child_q <= lidx;
					state_q <= (lidx < fill_ext) ? S_DNR : S_PLACE;
				end
				S_DNR: begin
					le_q    <= h_rdata;
					has_r_q <= (child_q + CH_W'(1)) < fill_ext;
					state_q <= S_DNLR;
				end
				S_DNLR: begin
					lrec_q  <= erd;
					re_q    <= h_rdata;
					state_q <= S_DNRR;
				end
				S_DNRR: begin
					if (moved) begin
						hole_q  <= SLOT_W'(pick_idx);
						state_q <= S_DNL;
					end else begin
						state_q <= S_PLACE;
					end
				end
				default: begin
					// Hold the result until the output register frees up
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_status_q <= st_q;
						out_rem_e_q  <= rem_e_q;
						out_rem_c_q  <= rem_c_q;
						out_count_q  <= fill_q;
						out_empty_q  <= fill_q == '0;
						out_full_q   <= full;
						state_q      <= S_IDLE;
					end
				end
			endcase

			// Drop the heap; restart the clearing pass when the epoch runs out or a pass
			// is running, otherwise bump the epoch on a clear and advance a running pass
			if (clear_req && (sweep_act_q || epoch_q == '1)) begin
				epoch_q     <= '0;
				sweep_q     <= '0;
				sweep_act_q <= 1'b1;
			end else begin
				if (clear_req) begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
				if (sweep_act_q) begin
					sweep_q <= sweep_q + ELEM_W'(1);
					if (sweep_q == '1) begin
						sweep_act_q <= 1'b0;
					end
				end
			end
			if (clear_req) begin
				fill_q <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign removed_element = out_rem_e_q;
	assign removed_cost    = out_rem_c_q;
	assign entry_count     = out_count_q;
	assign is_empty        = out_empty_q;
	assign is_full         = out_full_q;

	ibhq_ram #(.WIDTH(REC_W), .DEPTH(ELEM_COUNT), .AW(ELEM_W)) u_elem_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.re    (e_re),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	ibhq_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY), .AW(SLOT_W)) u_slot_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.re    (h_re),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

endmodule

>>> rtl/ibhq_checker.sv
// Port-level checks for the indexed binary heap queue, bound to the top level.
// Depends on ibhq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ibhq_checker
	import ibhq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [STATUS_W-1:0]      status,
	input logic [ELEM_W-1:0]        removed_element,
	input logic signed [COST_W-1:0] removed_cost,
	input logic [CNT_W-1:0]         entry_count,
	input logic                     is_empty,
	input logic                     is_full
);

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")
	`ASSERT_NOW(a_empty_flag, out_valid, is_empty == (entry_count == '0), "empty flag mismatch")
	`ASSERT_NOW(a_full_flag, out_valid, is_full == (entry_count == CNT_W'(CAPACITY)), "full flag mismatch")
	`ASSERT_NOW(a_fail_clean, out_valid && status != ST_OK, removed_element == '0 && removed_cost == '0, "failed step reports a removal")
	`ASSERT_NOW(a_empty_status, out_valid && status == ST_EMPTY, is_empty, "empty status on non-empty heap")

endmodule

bind indexed_binary_heap_queue ibhq_checker #(.CAPACITY(CAPACITY)) u_ibhq_checker (.*);
